/* rtl/rbd_pkg.sv */
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types, constants and slot arithmetic for the ring buffer deque.
// ----------------------------------------------------------------------------
package rbd_pkg;

	// Capacity of the ring and width of one stored entry.
	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;

	// Slot index, entry count and the sum used for ring wrap.
	localparam int SLOT_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SUM_W  = CNT_W + 1;

	// Fixed field widths of the beats.
	localparam int CMD_W   = 3;
	localparam int FIELD_W = 32;
	localparam int RIDX_W  = 6;
	localparam int TOTAL_W = 7;
	localparam int STAT_W  = 2;

	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ       = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd5;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd2;
	localparam logic [STAT_W-1:0] STAT_OUT_RANGE = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]          cmd;
		logic signed [FIELD_W-1:0] data_in;
		logic [RIDX_W-1:0]         read_index;
	} rbd_req_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] read_value;
		logic signed [FIELD_W-1:0] front_value;
		logic signed [FIELD_W-1:0] back_value;
		logic [TOTAL_W-1:0]        entry_total;
		logic                      is_empty;
		logic [STAT_W-1:0]         status;
	} rbd_rsp_t;

	// One access to the entry store: a write port and a read port.
	typedef struct packed {
		logic                  we;
		logic [SLOT_W-1:0]     waddr;
		logic [DATA_WIDTH-1:0] wdata;
		logic                  re;
		logic [SLOT_W-1:0]     raddr;
	} rbd_mem_t;

	// Slot of the entry at position pos from the front. Both operands stay
	// below DEPTH for any position that is held, so one subtract wraps it.
	function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] head,
	                                              input logic [CNT_W-1:0] pos);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(head) + SUM_W'(pos);
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return sum[SLOT_W-1:0];
	endfunction

endpackage

/* rtl/rbd_store.sv */
// ----------------------------------------------------------------------------
// rbd_store
// Entry store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rbd_store
	import rbd_pkg::*;
(
	input  logic                  clk,
	input  rbd_mem_t              mem,
	output logic [DATA_WIDTH-1:0] rd_data
);

	logic [DATA_WIDTH-1:0] ram_q [DEPTH];

	always_ff @(posedge clk) begin
		if (mem.we) begin
			ram_q[mem.waddr] <= mem.wdata;
		end
	end

	// The read data holds between reads, so the last value stays visible.
	always_ff @(posedge clk) begin
		if (mem.re) begin
			rd_data <= ram_q[mem.raddr];
		end
	end

endmodule

/* rtl/rbd_ctrl.sv */
// ----------------------------------------------------------------------------
// rbd_ctrl
// Command sequencer: pointer update and entry write, then three reads.
// ----------------------------------------------------------------------------
module rbd_ctrl
	import rbd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  rbd_req_t              req,
	output rbd_mem_t              mem,
	input  logic [DATA_WIDTH-1:0] rd_data,
	output logic                  res_valid,
	input  logic                  res_ready,
	output rbd_rsp_t              res
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_RD_IDX   = 3'd1;
	localparam logic [2:0] ST_RD_FRONT = 3'd2;
	localparam logic [2:0] ST_RD_BACK  = 3'd3;
	localparam logic [2:0] ST_RESULT   = 3'd4;

	logic [2:0]         state_q;
	logic [SLOT_W-1:0]  head_q;
	logic [CNT_W-1:0]   count_q;
	logic [RIDX_W-1:0]  ridx_q;
	logic [STAT_W-1:0]  status_q;
	logic [FIELD_W-1:0] read_q;
	logic [FIELD_W-1:0] front_q;

	logic               accept;
	logic               full;
	logic               empty;
	logic               idx_ok;
	logic [SLOT_W-1:0]  head_nxt;
	logic [CNT_W-1:0]   count_nxt;
	logic [STAT_W-1:0]  status_nxt;
	logic [SLOT_W-1:0]  head_dec;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign idx_ok    = (32'(req.read_index) < 32'(count_q));
	assign head_dec  = (head_q == '0) ? SLOT_W'(DEPTH - 1) : head_q - 1'b1;

	always_comb begin
		head_nxt   = head_q;
		count_nxt  = count_q;
		status_nxt = STAT_OK;
		mem        = '0;
		mem.wdata  = DATA_WIDTH'(unsigned'(req.data_in));
		case (req.cmd)
			CMD_PUSH_BACK: begin
				if (full) begin
					status_nxt = STAT_FULL;
				end else begin
					mem.we    = accept;
					mem.waddr = slot_of(head_q, count_q);
					count_nxt = count_q + 1'b1;
				end
			end
			CMD_PUSH_FRONT: begin
				if (full) begin
					status_nxt = STAT_FULL;
				end else begin
					mem.we    = accept;
					mem.waddr = head_dec;
					head_nxt  = head_dec;
					count_nxt = count_q + 1'b1;
				end
			end
			CMD_POP_BACK: begin
				if (empty) begin
					status_nxt = STAT_EMPTY;
				end else begin
					count_nxt = count_q - 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					status_nxt = STAT_EMPTY;
				end else begin
					count_nxt = count_q - 1'b1;
					head_nxt  = (32'(head_q) + 1 >= DEPTH) ? '0 : head_q + 1'b1;
				end
			end
			CMD_READ: begin
				if (!idx_ok) begin
					status_nxt = STAT_OUT_RANGE;
				end
			end
			CMD_CLEAR: begin
				head_nxt  = '0;
				count_nxt = '0;
			end
			default: begin
			end
		endcase

		// Reads run on the state after the command has taken effect.
		case (state_q)
			ST_RD_IDX: begin
				mem.re    = 1'b1;
				mem.raddr = slot_of(head_q, CNT_W'(ridx_q));
			end
			ST_RD_FRONT: begin
				mem.re    = 1'b1;
				mem.raddr = head_q;
			end
			ST_RD_BACK: begin
				mem.re    = 1'b1;
				mem.raddr = slot_of(head_q, count_q - 1'b1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						head_q  <= head_nxt;
						count_q <= count_nxt;
						state_q <= ST_RD_IDX;
					end
				end
				ST_RD_IDX:   state_q <= ST_RD_FRONT;
				ST_RD_FRONT: state_q <= ST_RD_BACK;
				ST_RD_BACK:  state_q <= ST_RESULT;
				ST_RESULT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ridx_q   <= req.read_index;
			status_q <= status_nxt;
		end
		if (state_q == ST_RD_FRONT) begin
			read_q <= (32'(ridx_q) < 32'(count_q)) ? FIELD_W'(rd_data) : '0;
		end
		if (state_q == ST_RD_BACK) begin
			front_q <= empty ? '0 : FIELD_W'(rd_data);
		end
	end

	assign res_valid       = (state_q == ST_RESULT);
	assign res.read_value  = read_q;
	assign res.front_value = front_q;
	assign res.back_value  = empty ? '0 : FIELD_W'(rd_data);
	assign res.entry_total = TOTAL_W'(count_q);
	assign res.is_empty    = empty;
	assign res.status      = status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above capacity");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(head_q) < DEPTH)
		else $error("head slot outside the ring");

	a_write_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		mem.we |-> (accept && !full))
		else $error("entry write outside an accepted push");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && full && (req.cmd == CMD_PUSH_BACK || req.cmd == CMD_PUSH_FRONT))
		|=> (count_q == CNT_W'(DEPTH)) && $stable(head_q))
		else $error("rejected push changed the state");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> res_valid && $stable(res))
		else $error("pending result changed");

endmodule

/* rtl/ring_buffer_deque.sv */
// ----------------------------------------------------------------------------
// ring_buffer_deque
// Fixed-capacity double-ended queue held in a ring of entry slots.
// ----------------------------------------------------------------------------
// Each command beat on req yields exactly one result beat on rsp. That beat
// reports the state after the command: the value at read_index, the front and
// back values (zero when not held), the entry total, an empty flag and a
// status. A push into a full deque or a pop from an empty one is rejected
// with its status and leaves everything unchanged. The block works on one
// command at a time. A command is taken at the edge where its pointer update
// and entry write happen. The store's single read port then serves three
// reads, one per cycle, for the indexed, front and back values. The result
// then waits until the output register takes it and is on rsp from then on.
// The next command can be taken only once the result has gone to the output
// register. An output register decouples the result side, so a command is
// taken while the previous result still waits on a stalled rsp. Clear resets
// only the pointers; entry contents are never cleared. A read of a slot
// outside the held range may take place, but its value is replaced by zero
// in the result.
module ring_buffer_deque
	import rbd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  rbd_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output rbd_rsp_t rsp
);

	rbd_mem_t              mem;
	logic [DATA_WIDTH-1:0] rd_data;
	logic                  res_valid;
	logic                  res_ready;
	rbd_rsp_t              res;
	logic                  rsp_valid_q;
	rbd_rsp_t              rsp_q;

	rbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.mem       (mem),
		.rd_data   (rd_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	rbd_store u_store (
		.clk     (clk),
		.mem     (mem),
		.rd_data (rd_data)
	);

	// The output register takes a new result whenever it is empty or its
	// current beat leaves in this cycle.
	assign res_ready = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* test/ring_buffer_deque_tb.sv */
// ----------------------------------------------------------------------------
// ring_buffer_deque_tb
// Self-checking bench for the ring buffer deque: every command beat is
// scored against an in-bench deque predictor or a typed-in result, under
// bursty traffic and random result back-pressure.
// ----------------------------------------------------------------------------
module ring_buffer_deque_tb;
	import rbd_pkg::*;

	// Codes 6 and 7 have no meaning in the block and must behave as no-ops.
	localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

	// Length of the run and its safety margins.
	localparam int RUN_BEATS   = 1550;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER  = 250;
	localparam int IDLE_LIMIT  = 3000;
	localparam int DRAIN_TAIL  = 20;

	// Modes of the random generator. Fill and drain walk the deque to its
	// limits, mix keeps it at mid level, and noise throws any code at it.
	typedef enum int {GEN_FILL, GEN_DRAIN, GEN_MIX, GEN_NOISE} gen_mode_t;

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_stall;
	rbd_req_t req;
	logic     rsp_valid;
	logic     rsp_stall;
	rbd_rsp_t rsp;

	ring_buffer_deque u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Deque predictor. It keeps its own ring, head and fill level and works
	// out the result beat that one command beat must produce.
	// ------------------------------------------------------------------------
	logic [DATA_WIDTH-1:0] ring_mem [DEPTH];
	int unsigned           ring_head;
	int unsigned           ring_fill;

	// Value at position pos from the front, or zero when pos is not held.
	function automatic logic [DATA_WIDTH-1:0] held_value(input int unsigned pos);
		if (pos >= ring_fill) begin
			return '0;
		end
		return ring_mem[(ring_head + pos) % DEPTH];
	endfunction

	task automatic step_deque(input rbd_req_t beat, output rbd_rsp_t res);
		logic [STAT_W-1:0] st;
		st = STAT_OK;
		case (beat.cmd)
			CMD_PUSH_BACK: begin
				if (ring_fill >= DEPTH) begin
					st = STAT_FULL;
				end else begin
					ring_mem[(ring_head + ring_fill) % DEPTH] = beat.data_in[DATA_WIDTH-1:0];
					ring_fill++;
				end
			end
			CMD_PUSH_FRONT: begin
				if (ring_fill >= DEPTH) begin
					st = STAT_FULL;
				end else begin
					ring_head = (ring_head == 0) ? DEPTH - 1 : ring_head - 1;
					ring_mem[ring_head] = beat.data_in[DATA_WIDTH-1:0];
					ring_fill++;
				end
			end
			CMD_POP_BACK: begin
				if (ring_fill == 0) begin
					st = STAT_EMPTY;
				end else begin
					ring_fill--;
				end
			end
			CMD_POP_FRONT: begin
				if (ring_fill == 0) begin
					st = STAT_EMPTY;
				end else begin
					ring_fill--;
					ring_head = (ring_head + 1) % DEPTH;
				end
			end
			CMD_READ: begin
				if (beat.read_index >= ring_fill) begin
					st = STAT_OUT_RANGE;
				end
			end
			CMD_CLEAR: begin
				// Only the pointers go back to zero; the slots keep their data.
				ring_head = 0;
				ring_fill = 0;
			end
			default: begin
			end
		endcase
		res.read_value  = held_value(32'(beat.read_index));
		res.front_value = held_value(0);
		res.back_value  = (ring_fill != 0) ? held_value(ring_fill - 1) : '0;
		res.entry_total = TOTAL_W'(ring_fill);
		res.is_empty    = (ring_fill == 0);
		res.status      = st;
	endtask

	// ------------------------------------------------------------------------
	// Stimulus store. Each command beat carries a flag that says whether its
	// result was typed into the directed table; if not, the predictor's
	// answer is what the result beat is scored against.
	// ------------------------------------------------------------------------
	rbd_req_t cmd_q[$];
	bit       typed_q[$];
	rbd_rsp_t typed_rsp_q[$];
	rbd_rsp_t owed_rsp_q[$];

	function automatic rbd_req_t mk_req(input logic [CMD_W-1:0] c,
	                                    input logic [FIELD_W-1:0] d,
	                                    input int unsigned ix);
		rbd_req_t r;
		r.cmd        = c;
		r.data_in    = d;
		r.read_index = RIDX_W'(ix);
		return r;
	endfunction

	function automatic rbd_rsp_t mk_rsp(input logic [FIELD_W-1:0] rv,
	                                    input logic [FIELD_W-1:0] fv,
	                                    input logic [FIELD_W-1:0] bv,
	                                    input int unsigned tot,
	                                    input logic [STAT_W-1:0] st);
		rbd_rsp_t r;
		r.read_value  = rv;
		r.front_value = fv;
		r.back_value  = bv;
		r.entry_total = TOTAL_W'(tot);
		r.is_empty    = (tot == 0);
		r.status      = st;
		return r;
	endfunction

	task automatic add_beat(input rbd_req_t b, input bit typed, input rbd_rsp_t want);
		cmd_q.push_back(b);
		typed_q.push_back(typed);
		typed_rsp_q.push_back(want);
	endtask

	// Scoreboard tallies.
	int errors;
	int rsp_count;
	int full_rejects;
	int empty_rejects;
	int range_misses;
	int peak_fill;

	// ------------------------------------------------------------------------
	// Result monitor. Sampling happens at the rising edge, so it sees the
	// values that were settled before the edge; the oldest owed result is
	// compared field by field with the beat that the block hands over.
	// ------------------------------------------------------------------------
	rbd_rsp_t want_rsp;

	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall) begin
			rsp_count++;
			if (owed_rsp_q.size() == 0) begin
				$error("result beat arrived with no command waiting for it");
				errors++;
			end else begin
				want_rsp = owed_rsp_q.pop_front();
				if (rsp.read_value !== want_rsp.read_value) begin
					$error("read_value: expected %0d, actual %0d",
					       want_rsp.read_value, rsp.read_value);
					errors++;
				end
				if (rsp.front_value !== want_rsp.front_value) begin
					$error("front_value: expected %0d, actual %0d",
					       want_rsp.front_value, rsp.front_value);
					errors++;
				end
				if (rsp.back_value !== want_rsp.back_value) begin
					$error("back_value: expected %0d, actual %0d",
					       want_rsp.back_value, rsp.back_value);
					errors++;
				end
				if (rsp.entry_total !== want_rsp.entry_total) begin
					$error("entry_total: expected %0d, actual %0d",
					       want_rsp.entry_total, rsp.entry_total);
					errors++;
				end
				if (rsp.is_empty !== want_rsp.is_empty) begin
					$error("is_empty: expected %0d, actual %0d",
					       want_rsp.is_empty, rsp.is_empty);
					errors++;
				end
				if (rsp.status !== want_rsp.status) begin
					$error("status: expected %0d, actual %0d",
					       want_rsp.status, rsp.status);
					errors++;
				end
				case (want_rsp.status)
					STAT_FULL:      full_rejects++;
					STAT_EMPTY:     empty_rejects++;
					STAT_OUT_RANGE: range_misses++;
					default: begin
					end
				endcase
				if (int'(want_rsp.entry_total) > peak_fill) begin
					peak_fill = int'(want_rsp.entry_total);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result side back-pressure. The receiver runs segments of its own mode:
	// no stall, light random stall, a fixed one-in-three pattern, or heavy
	// random stall. Once in the run it holds off for a long stretch so that
	// the output register and the block behind it fill up and req_stall
	// rises while the sender keeps offering beats.
	// ------------------------------------------------------------------------
	initial begin : receiver
		int  stall_mode;
		int  seg_left;
		int  phase;
		bit  hold_done;
		stall_mode = 0;
		seg_left   = 0;
		phase      = 0;
		hold_done  = 1'b0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!hold_done && rsp_count >= HOLD_AFTER) begin
				hold_done = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (seg_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				seg_left   = $urandom_range(10, 120);
			end
			seg_left--;
			phase++;
			case (stall_mode)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= ($urandom_range(0, 99) < 35);
				2: rsp_stall <= (phase % 3 == 0);
				default: rsp_stall <= ($urandom_range(0, 99) < 80);
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog. Any cycle in which neither channel moves a beat counts
	// toward the limit; a beat on either side starts the count again.
	// ------------------------------------------------------------------------
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Main flow: build the stimulus, reset, send every command beat, drain.
	// ------------------------------------------------------------------------
	initial begin : main_flow
		rbd_rsp_t  none;
		rbd_rsp_t  predicted;
		gen_mode_t gen_mode;
		int        seg_left;
		int        pick;
		int        gen_fill;
		int        idx;
		int        burst_left;
		int        gap_left;
		bit        took;
		logic [CMD_W-1:0]  c;
		int unsigned       ix;

		none          = '0;
		errors        = 0;
		rsp_count     = 0;
		full_rejects  = 0;
		empty_rejects = 0;
		range_misses  = 0;
		peak_fill     = 0;
		ring_head     = 0;
		ring_fill     = 0;
		for (int i = 0; i < DEPTH; i++) begin
			ring_mem[i] = '0;
		end

		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;

		// Directed table. Rows whose result is obvious carry it typed in:
		// the empty deque after reset, rejected pops, the extreme values at
		// both ends, an index past the count, and the state after a clear.
		add_beat(mk_req(CMD_READ, 32'h0000_0000, 0), 1'b1,
		         mk_rsp(32'h0, 32'h0, 32'h0, 0, STAT_OUT_RANGE));
		add_beat(mk_req(CMD_POP_BACK, 32'h0000_0000, 0), 1'b1,
		         mk_rsp(32'h0, 32'h0, 32'h0, 0, STAT_EMPTY));
		add_beat(mk_req(CMD_POP_FRONT, 32'hFFFF_FFFF, 63), 1'b1,
		         mk_rsp(32'h0, 32'h0, 32'h0, 0, STAT_EMPTY));
		add_beat(mk_req(CMD_PUSH_BACK, 32'h7FFF_FFFF, 0), 1'b1,
		         mk_rsp(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, STAT_OK));
		add_beat(mk_req(CMD_PUSH_FRONT, 32'h8000_0000, 0), 1'b1,
		         mk_rsp(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 2, STAT_OK));
		add_beat(mk_req(CMD_READ, 32'h0000_0000, 1), 1'b1,
		         mk_rsp(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 2, STAT_OK));
		add_beat(mk_req(CMD_READ, 32'hFFFF_FFFF, 63), 1'b1,
		         mk_rsp(32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 2, STAT_OUT_RANGE));
		add_beat(mk_req(CMD_PUSH_BACK, 32'hFFFF_FFFF, 2), 1'b0, none);
		add_beat(mk_req(CMD_PUSH_FRONT, 32'h0000_0000, 3), 1'b0, none);
		add_beat(mk_req(CMD_READ, 32'h0000_0000, 3), 1'b0, none);
		add_beat(mk_req(CMD_POP_BACK, 32'h1234_5678, 1), 1'b0, none);
		add_beat(mk_req(CMD_POP_FRONT, 32'h0000_0000, 0), 1'b0, none);
		add_beat(mk_req(CMD_SPARE_A, 32'hFFFF_FFFF, 63), 1'b0, none);
		add_beat(mk_req(CMD_SPARE_B, 32'h5555_AAAA, 1), 1'b0, none);
		add_beat(mk_req(CMD_CLEAR, 32'h0000_0000, 0), 1'b1,
		         mk_rsp(32'h0, 32'h0, 32'h0, 0, STAT_OK));
		add_beat(mk_req(CMD_READ, 32'h0000_0000, 0), 1'b1,
		         mk_rsp(32'h0, 32'h0, 32'h0, 0, STAT_OUT_RANGE));

		// Fill the ring to capacity from both ends, knock on it while full,
		// then empty it from both ends and knock on it while empty. This
		// also wraps the head below slot zero.
		for (int i = 0; i < DEPTH; i++) begin
			c = i[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
			add_beat(mk_req(c, $urandom, $urandom_range(0, 63)), 1'b0, none);
		end
		add_beat(mk_req(CMD_PUSH_BACK, $urandom, 63), 1'b0, none);
		add_beat(mk_req(CMD_PUSH_FRONT, $urandom, 0), 1'b0, none);
		for (int i = 0; i < DEPTH; i++) begin
			c = i[1] ? CMD_POP_FRONT : CMD_POP_BACK;
			add_beat(mk_req(c, $urandom, $urandom_range(0, 63)), 1'b0, none);
		end
		add_beat(mk_req(CMD_POP_BACK, $urandom, 0), 1'b0, none);
		add_beat(mk_req(CMD_POP_FRONT, $urandom, 0), 1'b0, none);

		// Random part. A rough fill level is tracked here only to steer
		// read indexes mostly inside the held range.
		gen_fill = 0;
		seg_left = 0;
		gen_mode = GEN_MIX;
		while (cmd_q.size() < RUN_BEATS) begin
			if (seg_left == 0) begin
				gen_mode = gen_mode_t'($urandom_range(0, 3));
				seg_left = $urandom_range(16, 96);
			end
			seg_left--;
			pick = $urandom_range(0, 99);
			case (gen_mode)
				GEN_FILL: begin
					if (pick < 85) begin
						c = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
					end else if (pick < 95) begin
						c = CMD_READ;
					end else begin
						c = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
					end
				end
				GEN_DRAIN: begin
					if (pick < 80) begin
						c = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
					end else if (pick < 92) begin
						c = CMD_READ;
					end else begin
						c = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
					end
				end
				GEN_MIX: begin
					if (pick < 35) begin
						c = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
					end else if (pick < 65) begin
						c = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
					end else if (pick < 92) begin
						c = CMD_READ;
					end else if (pick < 95) begin
						c = CMD_CLEAR;
					end else begin
						c = $urandom_range(0, 1) ? CMD_SPARE_B : CMD_SPARE_A;
					end
				end
				default: begin
					c = CMD_W'($urandom_range(0, 7));
				end
			endcase
			if (gen_fill > 0 && $urandom_range(0, 3) != 0) begin
				ix = $urandom_range(0, gen_fill - 1);
			end else begin
				ix = $urandom_range(0, 63);
			end
			add_beat(mk_req(c, $urandom, ix), 1'b0, none);
			case (c)
				CMD_PUSH_BACK, CMD_PUSH_FRONT: if (gen_fill < DEPTH) gen_fill++;
				CMD_POP_BACK, CMD_POP_FRONT:   if (gen_fill > 0) gen_fill--;
				CMD_CLEAR:                     gen_fill = 0;
				default: begin
				end
			endcase
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Sender. A beat is taken at an edge where req_valid is high and
		// req_stall is low; only then does the payload move on, so a stalled
		// beat stays put. Traffic comes in bursts of random length with
		// random gaps, and a gap of zero lets bursts run back to back.
		idx        = 0;
		burst_left = $urandom_range(1, 40);
		gap_left   = 0;
		while (idx < cmd_q.size()) begin
			@(posedge clk);
			took = req_valid && !req_stall;
			if (took) begin
				step_deque(cmd_q[idx], predicted);
				owed_rsp_q.push_back(typed_q[idx] ? typed_rsp_q[idx] : predicted);
				idx++;
			end
			if (took || !req_valid) begin
				if (idx >= cmd_q.size()) begin
					req_valid <= 1'b0;
				end else if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else begin
					req_valid <= 1'b1;
					req       <= cmd_q[idx];
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
		end

		// Drain: wait for every owed result, then for a further tail so that
		// any stray extra beat from the block would still be caught.
		while (owed_rsp_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_TAIL) @(posedge clk);

		if (owed_rsp_q.size() != 0) begin
			$error("%0d results never arrived", owed_rsp_q.size());
			errors++;
		end

		$display("Sent %0d command beats and scored %0d results, peak fill %0d of %0d.",
		         cmd_q.size(), rsp_count, peak_fill, DEPTH);
		$display("Saw %0d full rejects, %0d empty rejects, %0d out-of-range reads.",
		         full_rejects, empty_rejects, range_misses);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
